[hdl/tcpcs_pkg.sv]
// Shared types and constants for the TCP checksum block.
// No dependencies; imported by every module in hdl/.
package tcpcs_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned ProtoW  = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned LeftW   = 15;
  localparam int unsigned PseudoW = 19;
  localparam int unsigned InDataW = WordW + 2 * AddrW + ProtoW + LenW;
  localparam int unsigned OutDataW = WordW;

  localparam logic [WordW-1:0] OddByteMask = 16'hFF00;

  // One input item as held in the input register.
  typedef struct packed {
    logic [WordW-1:0]  segment_word;
    logic              last_word;
    logic [AddrW-1:0]  src_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [ProtoW-1:0] protocol;
    logic [LenW-1:0]   segment_length;
  } item_t;

  // Handshake between the input register and the checksum core.
  typedef struct packed {
    logic  valid;
    item_t item;
  } in_slot_t;

endpackage

[hdl/tcpcs_in_stage.sv]
// Input register of the TCP checksum block: unpacks and holds one item.
// Depends on tcpcs_pkg.
module tcpcs_in_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tcpcs_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           take_i,
  output tcpcs_pkg::in_slot_t            slot_o
);
  import tcpcs_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign s_axis_tready = !valid_q || take_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.segment_word   <= s_axis_tdata[WordW-1:0];
      item_q.last_word      <= s_axis_tlast;
      item_q.src_addr       <= s_axis_tdata[WordW +: AddrW];
      item_q.dst_addr       <= s_axis_tdata[WordW+AddrW +: AddrW];
      item_q.protocol       <= s_axis_tdata[WordW+2*AddrW +: ProtoW];
      item_q.segment_length <= s_axis_tdata[WordW+2*AddrW+ProtoW +: LenW];
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

endmodule

[hdl/tcpcs_core.sv]
// Checksum core: packet state, accumulator update, carry fold and result register.
// Depends on tcpcs_pkg.
module tcpcs_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcpcs_pkg::in_slot_t             slot_i,
  output logic                            take_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tcpcs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import tcpcs_pkg::*;

  logic [AccW-1:0]  acc_q, acc_d;
  logic             mid_q, mid_d;
  logic [LeftW-1:0] left_q, left_d;
  logic             odd_q, odd_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] csum_q, csum_d;

  item_t            it;
  logic [LenW:0]    len_inc;
  logic [LenW-1:0]  total;
  logic [LenW-1:0]  total_m1;
  logic [PseudoW-1:0] pseudo;
  logic [LeftW-1:0] left_after;
  logic             odd_now;
  logic [WordW-1:0] word_val;
  logic [AccW-1:0]  acc_new;
  logic [WordW:0]   fold1;
  logic [WordW-1:0] fold2;

  assign it = slot_i.item;

  // A non-last item never produces a result, so it may pass a stalled output.
  assign take_o = slot_i.valid && (!it.last_word || !out_valid_q || m_axis_tready);

  always_comb begin
    len_inc  = {1'b0, it.segment_length} + {{LenW{1'b0}}, 1'b1};
    total    = len_inc[LenW:1];
    total_m1 = total - {{(LenW-1){1'b0}}, 1'b1};
    pseudo   = PseudoW'(it.src_addr[15:0]) + PseudoW'(it.src_addr[31:16])
             + PseudoW'(it.dst_addr[15:0]) + PseudoW'(it.dst_addr[31:16])
             + PseudoW'(it.protocol) + PseudoW'(it.segment_length);

    if (!mid_q) begin
      odd_now    = it.segment_length[0];
      left_after = total_m1[LeftW-1:0];
    end else begin
      odd_now    = odd_q;
      left_after = left_q - {{(LeftW-1){1'b0}}, 1'b1};
    end

    // The final counted word of an odd-length segment carries one byte only.
    if (left_after == '0 && odd_now) begin
      word_val = it.segment_word & OddByteMask;
    end else begin
      word_val = it.segment_word;
    end

    acc_d  = acc_q;
    left_d = left_q;
    odd_d  = odd_q;
    mid_d  = mid_q;
    if (!mid_q) begin
      odd_d = odd_now;
      mid_d = 1'b1;
      if (total == '0) begin
        left_d = '0;
        acc_d  = AccW'(pseudo);
      end else begin
        left_d = left_after;
        acc_d  = AccW'(pseudo) + AccW'(word_val);
      end
    end else if (left_q != '0) begin
      left_d = left_after;
      acc_d  = acc_q + AccW'(word_val);
    end
    acc_new = acc_d;

    fold1 = {1'b0, acc_new[15:0]} + {1'b0, acc_new[31:16]};
    fold2 = fold1[WordW-1:0] + {{(WordW-1){1'b0}}, fold1[WordW]};

    csum_d      = csum_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (take_o && it.last_word) begin
      csum_d      = ~fold2;
      out_valid_d = 1'b1;
      acc_d       = '0;
      mid_d       = 1'b0;
      left_d      = '0;
      odd_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      mid_q       <= 1'b0;
      left_q      <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        acc_q  <= acc_d;
        mid_q  <= mid_d;
        left_q <= left_d;
        odd_q  <= odd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    csum_q <= csum_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = csum_q;

endmodule

[hdl/tcp_checksum_with_pseudo_header_top.sv]
// Top level of the TCP checksum block with pseudo-header.
// Depends on tcpcs_pkg, tcpcs_in_stage and tcpcs_core.
//
//  Channel  | Dir | Carries
//  s_axis   | in  | one segment word with its pseudo-header values; tlast ends the segment
//  m_axis   | out | the 16-bit checksum, one item per segment
//
// The block takes one item per cycle while m_axis is not stalling a last word. A
// segment's last word passes through the input register, then the accumulator and
// fold path set the result register, from which the checksum is valid on m_axis.
// Reset clears the packet state and both valid flags. A stalled m_axis holds only
// a last word in the input register; other words keep flowing.
module tcp_checksum_with_pseudo_header_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: segment_word[15:0], src_addr[47:16], dst_addr[79:48],
  // protocol[87:80], segment_length[103:88].
  input  logic [tcpcs_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: checksum[15:0].
  output logic [tcpcs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import tcpcs_pkg::*;

  in_slot_t slot;
  logic     take;

  tcpcs_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .slot_o        (slot)
  );

  tcpcs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .slot_i        (slot),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the TCP checksum block with pseudo-header.
// Depends on tcpcs_pkg and tcp_checksum_with_pseudo_header_top; predicts every checksum.
`timescale 1ns / 100ps

module testbench;
  import tcpcs_pkg::*;

  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned PhaseItems = 440;

  // One segment word with the pseudo-header values that travel beside it.
  typedef struct {
    logic [WordW-1:0]  word;
    logic              last;
    logic [AddrW-1:0]  src;
    logic [AddrW-1:0]  dst;
    logic [ProtoW-1:0] proto;
    logic [LenW-1:0]   len;
  } seg_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  seg_beat_t pending_beats[$];
  seg_beat_t beat_on_bus;
  logic [WordW-1:0] expected_sums[$];

  // Predictor state.
  logic [AccW-1:0]  run_sum;
  logic             in_packet;
  logic [LeftW-1:0] words_to_go;
  logic             odd_len;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stuck_cycles = 0;
  int unsigned error_count = 0;
  int unsigned sums_checked = 0;
  int unsigned packets_queued = 0;
  int unsigned beats_taken = 0;

  tcp_checksum_with_pseudo_header_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [WordW-1:0] counted_word(logic [WordW-1:0] w,
                                                    logic [LeftW-1:0] left);
    if (left == '0 && odd_len) return w & OddByteMask;
    return w;
  endfunction

  // Adds one accepted item to the running sum and queues a checksum on a last word.
  task automatic accumulate_beat(seg_beat_t b);
    logic [AccW-1:0] s;
    logic [16:0] total;
    if (!in_packet) begin
      s = AccW'(b.src[15:0]) + AccW'(b.src[31:16]) + AccW'(b.dst[15:0])
        + AccW'(b.dst[31:16]) + AccW'(b.proto) + AccW'(b.len);
      odd_len = b.len[0];
      total = (17'(b.len) + 17'd1) >> 1;
      if (total == '0) begin
        words_to_go = '0;
      end else begin
        words_to_go = LeftW'(total - 17'd1);
        s += AccW'(counted_word(b.word, words_to_go));
      end
      run_sum = s;
      in_packet = 1'b1;
    end else if (words_to_go != '0) begin
      words_to_go = words_to_go - 1'b1;
      run_sum += AccW'(counted_word(b.word, words_to_go));
    end
    if (b.last) begin
      s = {16'h0, run_sum[15:0]} + {16'h0, run_sum[31:16]};
      s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
      expected_sums.push_back(~s[15:0]);
      run_sum = '0;
      in_packet = 1'b0;
      words_to_go = '0;
      odd_len = 1'b0;
    end
  endtask

  // Driver: takes the next item from the pending queue, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      run_sum = '0;
      in_packet = 1'b0;
      words_to_go = '0;
      odd_len = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_beat(beat_on_bus);
        beats_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = pending_beats.pop_front();
          s_axis_tdata <= {beat_on_bus.len, beat_on_bus.proto, beat_on_bus.dst,
                           beat_on_bus.src, beat_on_bus.word};
          s_axis_tlast <= beat_on_bus.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each checksum with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected checksum %h", m_axis_tdata);
          error_count++;
        end else begin
          logic [WordW-1:0] want;
          want = expected_sums.pop_front();
          if (m_axis_tdata !== want) begin
            $error("checksum: expected %h, got %h", want, m_axis_tdata);
            error_count++;
          end
          sums_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_beats.size() == 0 && !s_axis_tvalid && expected_sums.size() == 0))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return WordW'($urandom);
    endcase
  endfunction

  function automatic seg_beat_t random_beat();
    seg_beat_t b;
    b.word = pick_word();
    b.last = 1'b0;
    b.src = $urandom;
    b.dst = $urandom;
    b.proto = ($urandom_range(1) == 0) ? ProtoW'(6) : ProtoW'($urandom);
    b.len = LenW'($urandom);
    return b;
  endfunction

  // Queues n items of one packet; the first carries the length, the last has tlast.
  task automatic queue_packet(logic [LenW-1:0] len, int n, logic [AddrW-1:0] src,
                              logic [AddrW-1:0] dst, logic [ProtoW-1:0] proto,
                              logic [WordW-1:0] first_word);
    seg_beat_t b;
    for (int i = 0; i < n; i++) begin
      b = random_beat();
      if (i == 0) begin
        b.len = len;
        b.src = src;
        b.dst = dst;
        b.proto = proto;
        b.word = first_word;
      end
      b.last = (i == n - 1);
      pending_beats.push_back(b);
    end
    packets_queued++;
  endtask

  task automatic queue_random_packet(output int n);
    logic [LenW-1:0] len;
    int words;
    int kind;
    seg_beat_t h;
    h = random_beat();
    kind = $urandom_range(99);
    len = ($urandom_range(19) == 0) ? LenW'($urandom) : LenW'($urandom_range(64));
    words = (int'(len) + 1) / 2;
    if (words < 1) words = 1;
    if (kind < 72) n = words;                                   // well formed
    else if (kind < 82) n = $urandom_range(1, words);           // tlast at or before the length
    else if (kind < 92) n = words + $urandom_range(1, 4);       // words past the length
    else n = 1;
    // Packets of more than 40 items are always cut short by an early tlast.
    if (n > 40) n = $urandom_range(1, 12);
    queue_packet(len, n, h.src, h.dst, h.proto, h.word);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_sums.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_directed();
    queue_packet(16'd0, 1, '0, '0, '0, 16'hFFFF);
    queue_packet(16'd0, 2, '1, '1, '1, 16'h1234);
    queue_packet(16'd1, 1, 32'hC0A8_0001, 32'h0A00_0002, 8'd6, 16'hFFFF);
    queue_packet(16'd2, 1, '1, '0, 8'd6, 16'hFFFF);
    queue_packet(16'd3, 2, 32'h7FFF_FFFF, 32'h8000_0000, 8'd17, 16'h0102);
    queue_packet(16'hFFFF, 2, '1, '1, '1, 16'hFFFF);
    queue_packet(16'd4, 4, '0, '1, '0, 16'h0000);
    queue_packet(16'd5, 2, 32'h0102_0304, 32'h0506_0708, 8'd6, 16'hA5A5);
    queue_packet(16'd6, 3, '1, '1, 8'd6, 16'hFFFF);
  endtask

  initial begin
    int n;
    int phase_count;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 45; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 45; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (phase == 0) queue_directed();
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        queue_random_packet(n);
        phase_count += n;
        // Keep the queue short so idle settings act on live traffic.
        while (pending_beats.size() > 64) @(negedge clk_i);
      end
      // The sender holds off here until every checksum has come back.
      wait_drained();
    end
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);
    if (expected_sums.size() != 0) begin
      $error("%0d checksums never arrived", expected_sums.size());
      error_count++;
    end
    $display("Sent %0d segments in %0d items over four idle/stall mixes;",
             packets_queued, beats_taken);
    $display("checked %0d checksums, %0d mismatches.", sums_checked, error_count);
    if (error_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/tcpcs_pkg.sv
hdl/tcpcs_in_stage.sv
hdl/tcpcs_core.sv
hdl/tcp_checksum_with_pseudo_header_top.sv
bench/testbench.sv
